FILE: rtl/bdhr_pkg.sv
// ============================================================================
// bdhr_pkg: shared types and constants for the button debouncer
// Holds the payload structs, the button status codes and the register map.
// ============================================================================
package bdhr_pkg;

    localparam int PIN_W = 8;
    localparam int ADDR_W = 5;

    typedef enum logic [1:0] {
        ST_NO_PRESSED = 2'd0,
        ST_PRESSED    = 2'd1,
        ST_ON_HOLD    = 2'd2
    } t_btn_status;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [2:0] REG_BUTTON_COUNT   = 3'd0;
    localparam logic [2:0] REG_ACTIVE_LEVEL   = 3'd1;
    localparam logic [2:0] REG_SAMPLE_DIVIDER = 3'd2;
    localparam logic [2:0] REG_HOLD_TIMEOUT   = 3'd3;
    localparam logic [2:0] REG_REPEAT_PERIOD  = 3'd4;

    typedef struct packed {
        logic             mode;
        logic [PIN_W-1:0] pin_levels;
        logic [2:0]       button_index;
    } t_in_item;

    typedef struct packed {
        logic       event_res;
        logic [1:0] status;
    } t_out_item;

endpackage

FILE: rtl/button_debounce_hold_repeat.sv
// ============================================================================
// button_debounce_hold_repeat: debounced button scanner with hold and repeat
// Scans the buttons one per cycle through a shared visit unit and reports
// press, long-press and auto-repeat events.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item): each transaction is
//   either a timer tick carrying all raw pin levels, or a status read of one
//   button. Every transaction yields exactly one result transaction on the
//   output channel (o_out_valid / i_out_ready / o_out_item).
//   Sequencing: a tick that starts a sampling pass visits buttons 0 .. n-1,
//   n = min(button_count, NUM_BUTTONS), one per cycle, through a single
//   visit unit, then goes to the done state. A read, or a tick that only
//   advances the divider, goes from idle straight to the done state. The next
//   transaction is accepted as soon as the sequencer is back in idle.
//   A finished result sits in the output register; a new transaction is
//   accepted while it waits. If the receiver stalls, the following result
//   holds in the done state until the output register frees up.
//   Reset: all buttons start released and acknowledged, the debounce
//   history holds the inactive level, counters clear and the registers
//   take their defaults (8 buttons, active low, divider 1, hold 50,
//   repeat 10). The APB port is always ready; write only while idle.
// ============================================================================
module button_debounce_hold_repeat #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  bdhr_pkg::t_in_item      i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output bdhr_pkg::t_out_item     o_out_item,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [bdhr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import bdhr_pkg::*;

    // Index width for the per-button state, and a count width that holds
    // both the 4-bit register and NUM_BUTTONS itself.
    localparam int BW   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int CNTW = (BW + 1 > 4) ? BW + 1 : 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Sequencer and result registers
    t_state      r_state, n_state;
    logic [BW-1:0] r_b, n_b;
    logic [BW-1:0] r_last, n_last;
    logic        r_event, n_event;
    logic [1:0]  r_status, n_status;
    logic [PIN_W-1:0] r_pins, n_pins;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    // Shared counters
    logic [7:0]  r_div, n_div;
    logic [7:0]  r_rep, n_rep;

    // Per-button state
    logic [2:0]  r_hist   [NUM_BUTTONS];
    logic [2:0]  n_hist   [NUM_BUTTONS];
    logic        r_stable [NUM_BUTTONS];
    logic        n_stable [NUM_BUTTONS];
    logic [7:0]  r_cd     [NUM_BUTTONS];
    logic [7:0]  n_cd     [NUM_BUTTONS];
    t_btn_status r_cur    [NUM_BUTTONS];
    t_btn_status n_cur    [NUM_BUTTONS];
    t_btn_status r_ack    [NUM_BUTTONS];
    t_btn_status n_ack    [NUM_BUTTONS];

    // Configuration registers
    logic [3:0]  r_btn_cnt;
    logic        r_act_lvl;
    logic [7:0]  r_smp_div;
    logic [7:0]  r_hold_to;
    logic [7:0]  r_rep_per;

    // Visit unit signals
    logic [NUM_BUTTONS-1:0] w_pins_ext;
    logic        w_level;
    logic [2:0]  w_h;
    logic [7:0]  w_cd_dec;
    logic [7:0]  w_cd;
    logic        w_stable;
    t_btn_status w_st;
    t_btn_status w_ack;
    logic [7:0]  w_rep;
    logic        w_evt;

    // Input decode
    logic        w_in_acc;
    logic        w_cfg_wr;
    logic [7:0]  w_div_inc;
    logic [CNTW-1:0] w_cnt_ext;
    logic [CNTW-1:0] w_cnt_sat;
    logic        w_rd_ok;
    logic [BW-1:0] w_rd_addr;

    assign pready      = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_wr    = psel && penable && pwrite;

    // Buttons beyond the pin field read level 0
    for (genvar gi = 0; gi < NUM_BUTTONS; gi++) begin : g_pin
        if (gi < PIN_W) begin : g_real
            assign w_pins_ext[gi] = r_pins[gi];
        end else begin : g_zero
            assign w_pins_ext[gi] = 1'b0;
        end
    end

    // Register readback
    always_comb begin
        case (paddr[4:2])
            REG_BUTTON_COUNT:   prdata = {28'd0, r_btn_cnt};
            REG_ACTIVE_LEVEL:   prdata = {31'd0, r_act_lvl};
            REG_SAMPLE_DIVIDER: prdata = {24'd0, r_smp_div};
            REG_HOLD_TIMEOUT:   prdata = {24'd0, r_hold_to};
            REG_REPEAT_PERIOD:  prdata = {24'd0, r_rep_per};
            default:            prdata = 32'd0;
        endcase
    end

    // Tick decode: divider step and saturated scan length
    assign w_div_inc = r_div + 8'd1;
    assign w_cnt_ext = CNTW'(r_btn_cnt);
    assign w_cnt_sat = (w_cnt_ext > CNTW'(NUM_BUTTONS)) ? CNTW'(NUM_BUTTONS) : w_cnt_ext;
    assign w_rd_ok   = (32'(i_in_item.button_index) < 32'(NUM_BUTTONS));
    assign w_rd_addr = BW'(i_in_item.button_index);

    // Shared visit unit: debounce, hold countdown, event and repeat for button r_b
    always_comb begin
        w_level  = w_pins_ext[r_b];
        w_h      = {r_hist[r_b][1:0], w_level};
        w_cd     = r_cd[r_b];
        w_st     = r_cur[r_b];
        w_ack    = r_ack[r_b];
        w_stable = r_stable[r_b];
        w_rep    = r_rep;
        w_evt    = r_event;
        w_cd_dec = w_cd - 8'd1;

        // Run the hold countdown; expiry means on_hold
        if (w_cd != 8'd0) begin
            w_cd = w_cd_dec;
            if (w_cd_dec == 8'd0) begin
                w_st = ST_ON_HOLD;
            end
        end

        // Accept a new stable level only when all three samples agree
        if ((w_h == 3'b000 || w_h == 3'b111) && (w_level != w_stable)) begin
            w_stable = w_level;
            if (w_level == r_act_lvl) begin
                w_cd = r_hold_to;
            end else begin
                w_st = (w_cd != 8'd0) ? ST_PRESSED : ST_NO_PRESSED;
                w_cd = 8'd0;
            end
        end

        // Raise the event on an unacknowledged change; repeat while held
        if (w_st != w_ack) begin
            w_evt = 1'b1;
        end else if (w_st == ST_ON_HOLD) begin
            w_rep = r_rep + 8'd1;
            if (w_rep == r_rep_per) begin
                w_rep = 8'd0;
                w_ack = ST_NO_PRESSED;
                w_evt = 1'b1;
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_b         = r_b;
        n_last      = r_last;
        n_event     = r_event;
        n_status    = r_status;
        n_pins      = r_pins;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_div       = r_div;
        n_rep       = r_rep;
        n_hist      = r_hist;
        n_stable    = r_stable;
        n_cd        = r_cd;
        n_cur       = r_cur;
        n_ack       = r_ack;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_event  = 1'b0;
                    n_status = 2'd0;
                    n_pins   = i_in_item.pin_levels;
                    n_b      = '0;
                    n_state  = S_DONE;
                    if (i_in_item.mode == MODE_TICK) begin
                        n_div = w_div_inc;
                        if (w_div_inc == r_smp_div) begin
                            n_div = 8'd0;
                            if (w_cnt_sat != '0) begin
                                n_last  = BW'(w_cnt_sat - CNTW'(1));
                                n_state = S_SCAN;
                            end
                        end
                    end else if (w_rd_ok) begin
                        // Return status, clear pressed, acknowledge
                        n_status = r_cur[w_rd_addr];
                        if (r_cur[w_rd_addr] == ST_PRESSED) begin
                            n_cur[w_rd_addr] = ST_NO_PRESSED;
                            n_ack[w_rd_addr] = ST_NO_PRESSED;
                        end else begin
                            n_ack[w_rd_addr] = r_cur[w_rd_addr];
                        end
                    end
                end
            end
            S_SCAN: begin
                n_hist[r_b]   = w_h;
                n_stable[r_b] = w_stable;
                n_cd[r_b]     = w_cd;
                n_cur[r_b]    = w_st;
                n_ack[r_b]    = w_ack;
                n_rep         = w_rep;
                n_event       = w_evt;
                if (r_b == r_last) begin
                    n_state = S_DONE;
                end else begin
                    n_b = r_b + BW'(1);
                end
            end
            S_DONE: begin
                // Hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out.event_res = r_event;
                    n_out.status    = r_status;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_b         <= '0;
            r_last      <= '0;
            r_event     <= 1'b0;
            r_status    <= 2'd0;
            r_out_valid <= 1'b0;
            r_div       <= 8'd0;
            r_rep       <= 8'd0;
            r_btn_cnt   <= 4'd8;
            r_act_lvl   <= 1'b0;
            r_smp_div   <= 8'd1;
            r_hold_to   <= 8'd50;
            r_rep_per   <= 8'd10;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_hist[i]   <= 3'b111;
                r_stable[i] <= 1'b1;
                r_cd[i]     <= 8'd0;
                r_cur[i]    <= ST_NO_PRESSED;
                r_ack[i]    <= ST_NO_PRESSED;
            end
        end else begin
            r_state     <= n_state;
            r_b         <= n_b;
            r_last      <= n_last;
            r_event     <= n_event;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            r_div       <= n_div;
            r_rep       <= n_rep;
            r_hist      <= n_hist;
            r_stable    <= n_stable;
            r_cd        <= n_cd;
            r_cur       <= n_cur;
            r_ack       <= n_ack;
            if (w_cfg_wr) begin
                case (paddr[4:2])
                    REG_BUTTON_COUNT:   r_btn_cnt <= pwdata[3:0];
                    REG_ACTIVE_LEVEL:   r_act_lvl <= pwdata[0];
                    REG_SAMPLE_DIVIDER: r_smp_div <= pwdata[7:0];
                    REG_HOLD_TIMEOUT:   r_hold_to <= pwdata[7:0];
                    REG_REPEAT_PERIOD:  r_rep_per <= pwdata[7:0];
                    default: begin
                    end
                endcase
            end
        end
        r_pins <= n_pins;
        r_out  <= n_out;
    end

endmodule

FILE: rtl/bdhr_checker.sv
// ============================================================================
// bdhr_checker: port-level checks for the button debouncer
// Watches the top-level ports and flags illegal result behavior.
// ============================================================================
module bdhr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input bdhr_pkg::t_out_item o_out_item,
    input logic                pready
);
    import bdhr_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Status code 3 is never produced
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status != 2'd3)
        else $error("undefined status code");

    // Ticks carry no status and reads carry no event
    a_evt_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.event_res && o_out_item.status != 2'd0))
        else $error("event and status both set");

    // Drop any result on reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind button_debounce_hold_repeat bdhr_checker u_bdhr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item),
    .pready      (pready)
);
